@@ hdl/ketar_pkg.sv @@
// shared types, codes and defaults for the key edge tracker with auto-repeat
// no dependencies; imported by every module of the block but ketar_ram
`default_nettype none

package ketar_pkg;

    // defaults for the top-level parameters
    localparam int KEY_COUNT_DEF  = 512;
    localparam int TIMER_BITS_DEF = 24;

    // command queue depth between front and back
    localparam int Q_DEPTH = 4;

    // fixed field widths of the stream items
    localparam int KEY_W   = 9;
    localparam int DELTA_W = 20;
    localparam int CMD_W   = 2;
    localparam int PHASE_W = 2;
    localparam int CFG_W   = 24;
    localparam int CFG_IDX_W = 2;

    // command codes on the input stream
    localparam logic [CMD_W-1:0] CMD_EVENT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POLL  = 2'd2;

    // key phases
    localparam logic [PHASE_W-1:0] PH_IDLE     = 2'd0;
    localparam logic [PHASE_W-1:0] PH_PRESSED  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_HELD     = 2'd2;
    localparam logic [PHASE_W-1:0] PH_RELEASED = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DAS_DELAY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ARR_PERIOD = 2'd1;

    localparam logic [CFG_W-1:0] DAS_DELAY_RST  = 24'd167000;
    localparam logic [CFG_W-1:0] ARR_PERIOD_RST = 24'd33000;

    // work kinds handed from front to back
    typedef logic [1:0] t_kind;
    localparam t_kind K_EVENT    = 2'd0;
    localparam t_kind K_TICK     = 2'd1;
    localparam t_kind K_POLL     = 2'd2;
    localparam t_kind K_POLL_OOR = 2'd3;

    typedef struct packed {
        t_kind              kind;
        logic [KEY_W-1:0]   key_code;
        logic               key_down;
        logic [DELTA_W-1:0] delta_time;
    } t_cmd;

endpackage

`default_nettype wire

@@ hdl/ketar_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module ketar_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                     i_clk,
    input  wire                     i_wr_en,
    input  wire [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire [WIDTH-1:0]         i_wr_data,
    input  wire                     i_rd_en,
    input  wire [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]        o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/ketar_fifo.sv @@
// short command queue between the front classifier and the back engine
// depends on ketar_pkg for the command type
`default_nettype none

module ketar_fifo #(
    parameter int DEPTH = 4
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_push,
    input  wire ketar_pkg::t_cmd i_push_data,
    output logic               o_full,
    input  wire                i_pop,
    output logic               o_valid,
    output ketar_pkg::t_cmd    o_head
);
    import ketar_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_cmd          r_buf [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [PW:0]   r_count;

    assign o_full  = (r_count == (PW+1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_buf[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH-1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH-1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (PW+1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (PW+1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

@@ hdl/ketar_front.sv @@
// front end: takes input transfers, drops no-op commands and events on out-of-range
// keys, tags the rest; depends on ketar_pkg; feeds ketar_fifo
`default_nettype none

module ketar_front #(
    parameter int KEY_COUNT = ketar_pkg::KEY_COUNT_DEF
) (
    input  wire                          i_s_valid,
    output logic                         o_s_ready,
    input  wire [ketar_pkg::CMD_W-1:0]   i_cmd,
    input  wire [ketar_pkg::KEY_W-1:0]   i_key_code,
    input  wire                          i_key_down,
    input  wire [ketar_pkg::DELTA_W-1:0] i_delta_time,
    input  wire                          i_init_done,
    input  wire                          i_q_full,
    output logic                         o_push,
    output ketar_pkg::t_cmd              o_push_data
);
    import ketar_pkg::*;

    localparam int IDX_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    localparam int KW    = (IDX_W > KEY_W) ? IDX_W : KEY_W;

    logic [KW-1:0] key_ext;
    logic          key_ok;
    logic          keep;
    t_kind         kind;

    assign key_ext = KW'(i_key_code);
    assign key_ok  = ({1'b0, key_ext} < (KW+1)'(KEY_COUNT));

    always_comb begin
        keep = 1'b0;
        kind = K_EVENT;
        case (i_cmd)
            CMD_EVENT: begin
                keep = key_ok;
                kind = K_EVENT;
            end
            CMD_TICK: begin
                keep = 1'b1;
                kind = K_TICK;
            end
            CMD_POLL: begin
                keep = 1'b1;
                kind = key_ok ? K_POLL : K_POLL_OOR;
            end
            default: begin
                keep = 1'b0;
                kind = K_EVENT;
            end
        endcase
    end

    // no transfers while the store is being cleared after reset or the queue is full
    assign o_s_ready = i_init_done && !i_q_full;
    assign o_push    = i_s_valid && o_s_ready && keep;

    assign o_push_data.kind       = kind;
    assign o_push_data.key_code   = i_key_code;
    assign o_push_data.key_down   = i_key_down;
    assign o_push_data.delta_time = i_delta_time;

endmodule

`default_nettype wire

@@ hdl/ketar_back.sv @@
// back end: read-modify-write engine over the per-key store, table walk for
// ticks, clearing pass after reset and the result register
// depends on ketar_pkg and ketar_ram
`default_nettype none

module ketar_back #(
    parameter int KEY_COUNT  = ketar_pkg::KEY_COUNT_DEF,
    parameter int TIMER_BITS = ketar_pkg::TIMER_BITS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_q_valid,
    input  wire ketar_pkg::t_cmd         i_q_head,
    output logic                         o_q_pop,
    input  wire [ketar_pkg::CFG_W-1:0]   i_das_delay,
    input  wire [ketar_pkg::CFG_W-1:0]   i_arr_period,
    output logic                         o_init_done,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output logic                         o_fire,
    output logic [ketar_pkg::PHASE_W-1:0] o_key_phase
);
    import ketar_pkg::*;

    localparam int IDX_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    localparam int KW    = (IDX_W > KEY_W) ? IDX_W : KEY_W;
    localparam int TB    = TIMER_BITS;
    // entry: armed | repeat timer | delay timer | phase
    localparam int DLY_LO = PHASE_W;
    localparam int REP_LO = PHASE_W + TB;
    localparam int ARM_B  = PHASE_W + 2*TB;
    localparam int ENT_W  = ARM_B + 1;
    localparam int SW     = ((TB > DELTA_W) ? TB : DELTA_W) + 1;
    localparam int CW     = (TB > CFG_W) ? TB : CFG_W;

    localparam logic [1:0] ST_CLR  = 2'd0;
    localparam logic [1:0] ST_IDLE = 2'd1;
    localparam logic [1:0] ST_EXEC = 2'd2;
    localparam logic [1:0] ST_TICK = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [IDX_W-1:0] r_addr;
    t_cmd             r_cmd;
    logic             r_out_valid, n_out_valid;
    logic             r_fire, n_fire;
    logic [PHASE_W-1:0] r_phase, n_phase;

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [ENT_W-1:0] rd_data;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [ENT_W-1:0] wr_data;

    logic [KW-1:0]    key_ext;
    logic [IDX_W-1:0] head_addr;
    logic             out_free;
    logic             last_idx;

    ketar_ram #(
        .WIDTH (ENT_W),
        .DEPTH (KEY_COUNT)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign key_ext   = KW'(i_q_head.key_code);
    assign head_addr = key_ext[IDX_W-1:0];
    assign out_free  = !r_out_valid || i_out_ready;
    assign last_idx  = (r_idx == IDX_W'(KEY_COUNT-1));

    // fields of the entry just read
    logic [PHASE_W-1:0] e_phase;
    logic [TB-1:0]      e_dly;
    logic [TB-1:0]      e_rep;
    logic               e_arm;

    assign e_phase = rd_data[PHASE_W-1:0];
    assign e_dly   = rd_data[DLY_LO +: TB];
    assign e_rep   = rd_data[REP_LO +: TB];
    assign e_arm   = rd_data[ARM_B];

    // tick update of one entry
    logic [PHASE_W-1:0] t_phase;
    logic [SW-1:0]      dly_sum;
    logic [SW-1:0]      rep_sum;
    logic [TB-1:0]      t_dly;
    logic [TB-1:0]      t_rep;
    logic [ENT_W-1:0]   tick_ent;

    always_comb begin
        case (e_phase)
            PH_PRESSED:  t_phase = PH_HELD;
            PH_RELEASED: t_phase = PH_IDLE;
            default:     t_phase = e_phase;
        endcase
        dly_sum = SW'(e_dly) + SW'(r_cmd.delta_time);
        rep_sum = SW'(e_rep) + SW'(r_cmd.delta_time);
        t_dly   = e_dly;
        t_rep   = e_rep;
        if (t_phase == PH_HELD) begin
            // saturate at the top of the timer range
            t_dly = (|dly_sum[SW-1:TB]) ? {TB{1'b1}} : dly_sum[TB-1:0];
            if (e_arm) begin
                t_rep = (|rep_sum[SW-1:TB]) ? {TB{1'b1}} : rep_sum[TB-1:0];
            end
        end
        tick_ent = {e_arm, t_rep, t_dly, t_phase};
    end

    // event and poll update of one entry
    logic             p_fire;
    logic [ENT_W-1:0] cmd_ent;
    logic [CW-1:0]    dly_cmp;
    logic [CW-1:0]    rep_cmp;

    assign dly_cmp = CW'(e_dly);
    assign rep_cmp = CW'(e_rep);

    always_comb begin
        p_fire  = 1'b0;
        cmd_ent = rd_data;
        if (r_cmd.kind == K_EVENT) begin
            if (r_cmd.key_down) begin
                cmd_ent[PHASE_W-1:0] = (e_phase == PH_HELD) ? PH_HELD : PH_PRESSED;
            end else begin
                cmd_ent[PHASE_W-1:0] = PH_RELEASED;
            end
        end else begin
            case (e_phase)
                PH_PRESSED: begin
                    cmd_ent = {1'b0, {TB{1'b0}}, {TB{1'b0}}, e_phase};
                    p_fire  = 1'b1;
                end
                PH_HELD: begin
                    if (!e_arm && dly_cmp >= CW'(i_das_delay)) begin
                        cmd_ent[ARM_B]         = 1'b1;
                        cmd_ent[REP_LO +: TB]  = '0;
                        p_fire                 = 1'b1;
                    end else if (e_arm && rep_cmp >= CW'(i_arr_period)) begin
                        cmd_ent[REP_LO +: TB]  = '0;
                        p_fire                 = 1'b1;
                    end
                end
                default: begin
                    cmd_ent = {1'b0, {TB{1'b0}}, {TB{1'b0}}, e_phase};
                end
            endcase
        end
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !i_out_ready;
        n_fire      = r_fire;
        n_phase     = r_phase;
        o_q_pop     = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = head_addr;
        wr_en       = 1'b0;
        wr_addr     = r_idx;
        wr_data     = tick_ent;
        case (r_state)
            ST_CLR: begin
                wr_en   = 1'b1;
                wr_data = '0;
                if (last_idx) begin
                    n_state = ST_IDLE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            ST_IDLE: begin
                if (i_q_valid) begin
                    if (i_q_head.kind == K_POLL_OOR) begin
                        // out-of-range key: result only, no store access
                        if (out_free) begin
                            o_q_pop     = 1'b1;
                            n_out_valid = 1'b1;
                            n_fire      = 1'b0;
                            n_phase     = PH_IDLE;
                        end
                    end else begin
                        o_q_pop = 1'b1;
                        rd_en   = 1'b1;
                        if (i_q_head.kind == K_TICK) begin
                            rd_addr = '0;
                            n_idx   = '0;
                            n_state = ST_TICK;
                        end else begin
                            n_state = ST_EXEC;
                        end
                    end
                end
            end
            ST_EXEC: begin
                wr_addr = r_addr;
                wr_data = cmd_ent;
                if (r_cmd.kind == K_EVENT) begin
                    wr_en   = 1'b1;
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    wr_en       = 1'b1;
                    n_out_valid = 1'b1;
                    n_fire      = p_fire;
                    n_phase     = e_phase;
                    n_state     = ST_IDLE;
                end
            end
            ST_TICK: begin
                // write back key r_idx while key r_idx+1 is read
                wr_en = 1'b1;
                if (last_idx) begin
                    n_state = ST_IDLE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_idx + IDX_W'(1);
                    n_idx   = r_idx + IDX_W'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fire  <= n_fire;
        r_phase <= n_phase;
        if (o_q_pop) begin
            r_cmd  <= i_q_head;
            r_addr <= head_addr;
        end
    end

    assign o_init_done = (r_state != ST_CLR);
    assign o_out_valid = r_out_valid;
    assign o_fire      = r_fire;
    assign o_key_phase = r_phase;

endmodule

`default_nettype wire

@@ hdl/key_edge_tracker_auto_repeat.sv @@
// top level of the key edge tracker with typematic auto-repeat
// depends on ketar_pkg, ketar_front, ketar_fifo, ketar_back (and ketar_ram)
//
// Tracks idle/pressed/held/released per key code with delay and repeat timers.
// Commands arrive on the s_ stream (tuser = command), poll results leave on the
// m_ stream. All per-key state sits in one single-port-per-direction ram; a
// front stage tags commands into a four-entry queue that the back engine drains.
// After reset the store is cleared entry by entry, during which s_tready stays
// low. A key event or poll reads the ram, then writes the entry back; a poll of
// an out-of-range key makes no store access; a tick walks the whole store.
// Dropped commands (cmd 3, events on out-of-range keys) cost only their input
// transfer. Configuration writes are always accepted.
`default_nettype none

module key_edge_tracker_auto_repeat #(
    parameter int KEY_COUNT  = ketar_pkg::KEY_COUNT_DEF,
    parameter int TIMER_BITS = ketar_pkg::TIMER_BITS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // input stream
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [31:0]  s_tdata,   // key_code[8:0], key_down[9], delta_time[29:10], zero[31:30]
    input  wire [1:0]   s_tuser,   // cmd[1:0]
    // result stream
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [7:0]  m_tdata,   // fire[0], key_phase[2:1], zero[7:3]
    // configuration writes
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire [ketar_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [ketar_pkg::CFG_W-1:0]       i_cfg_data
);
    import ketar_pkg::*;

    logic [CFG_W-1:0] r_das_delay;
    logic [CFG_W-1:0] r_arr_period;

    logic   q_full;
    logic   q_push;
    t_cmd   q_push_data;
    logic   q_pop;
    logic   q_valid;
    t_cmd   q_head;
    logic   init_done;
    logic   out_fire;
    logic [PHASE_W-1:0] out_phase;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_das_delay  <= DAS_DELAY_RST;
            r_arr_period <= ARR_PERIOD_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DAS_DELAY:  r_das_delay  <= i_cfg_data;
                CFG_ARR_PERIOD: r_arr_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ketar_front #(
        .KEY_COUNT (KEY_COUNT)
    ) u_front (
        .i_s_valid    (s_tvalid),
        .o_s_ready    (s_tready),
        .i_cmd        (s_tuser),
        .i_key_code   (s_tdata[8:0]),
        .i_key_down   (s_tdata[9]),
        .i_delta_time (s_tdata[29:10]),
        .i_init_done  (init_done),
        .i_q_full     (q_full),
        .o_push       (q_push),
        .o_push_data  (q_push_data)
    );

    ketar_fifo #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_valid     (q_valid),
        .o_head      (q_head)
    );

    ketar_back #(
        .KEY_COUNT  (KEY_COUNT),
        .TIMER_BITS (TIMER_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_head     (q_head),
        .o_q_pop      (q_pop),
        .i_das_delay  (r_das_delay),
        .i_arr_period (r_arr_period),
        .o_init_done  (init_done),
        .o_out_valid  (m_tvalid),
        .i_out_ready  (m_tready),
        .o_fire       (out_fire),
        .o_key_phase  (out_phase)
    );

    assign m_tdata = {5'b0, out_phase, out_fire};

endmodule

`default_nettype wire

@@ test/key_edge_tracker_auto_repeat_tb.sv @@
// self-checking bench for key_edge_tracker_auto_repeat: a queued stream driver,
// a result monitor and an in-bench model of the per-key phase and repeat timers
// depends on ketar_pkg and the rtl of the block
`default_nettype none

module key_edge_tracker_auto_repeat_tb;

    import ketar_pkg::*;

    localparam int KEY_COUNT   = KEY_COUNT_DEF;
    localparam int TIMER_BITS  = TIMER_BITS_DEF;
    localparam int DT_MAX      = 1000000;
    localparam int LONG_HOLD   = 500;
    // a tick in the back engine plus a full queue of ticks behind it
    localparam int DRAIN_WAIT  = (Q_DEPTH + 1) * (KEY_COUNT + 2) + 32;
    localparam int RUN_LIMIT   = 3000000;
    localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};
    localparam logic [KEY_W-1:0] KEY_LAST = KEY_W'(KEY_COUNT - 1);
    localparam logic [DELTA_W-1:0] DT_FULL = DELTA_W'(DT_MAX);

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [KEY_W-1:0]   key;
        logic               down;
        logic [DELTA_W-1:0] dt;
    } t_key_cmd;

    typedef struct packed {
        logic               fire;
        logic [PHASE_W-1:0] phase;
    } t_poll_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    // model state
    logic [PHASE_W-1:0]    key_phase_tab [KEY_COUNT];
    logic [TIMER_BITS-1:0] held_time [KEY_COUNT];
    logic [TIMER_BITS-1:0] repeat_time [KEY_COUNT];
    logic                  armed [KEY_COUNT];
    logic [CFG_W-1:0]      das_cfg;
    logic [CFG_W-1:0]      arr_cfg;

    t_key_cmd     pending_cmds [$];
    t_poll_result polls_due [$];
    t_key_cmd     cur_cmd;

    int tx_gap = 0;
    int tx_quiet = 0;
    int rx_hold = 0;
    int rx_quiet = 0;
    logic long_hold_done = 1'b0;
    int cycle_count = 0;
    int error_count = 0;
    int events_done = 0;
    int ticks_done = 0;
    int polls_done = 0;
    int results_checked = 0;
    int fires_seen = 0;

    key_edge_tracker_auto_repeat uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [TIMER_BITS-1:0] sat_add(input logic [TIMER_BITS-1:0] t,
                                                      input logic [DELTA_W-1:0] d);
        logic [63:0] sum;
        sum = 64'(t) + 64'(d);
        if (sum > 64'(TIMER_MAX)) begin
            return TIMER_MAX;
        end
        return sum[TIMER_BITS-1:0];
    endfunction

    function automatic void clear_timers(input int k);
        held_time[k] = '0;
        repeat_time[k] = '0;
        armed[k] = 1'b0;
    endfunction

    // applies one accepted command to the model, queues the poll result it causes
    function automatic void track_command(input t_key_cmd c);
        t_poll_result r;
        int k;
        if (c.cmd == CMD_EVENT) begin
            events_done++;
            if (int'(c.key) < KEY_COUNT) begin
                if (c.down) begin
                    if (key_phase_tab[c.key] != PH_HELD) key_phase_tab[c.key] = PH_PRESSED;
                end else begin
                    key_phase_tab[c.key] = PH_RELEASED;
                end
            end
        end else if (c.cmd == CMD_TICK) begin
            ticks_done++;
            for (k = 0; k < KEY_COUNT; k++) begin
                if (key_phase_tab[k] == PH_PRESSED) key_phase_tab[k] = PH_HELD;
                else if (key_phase_tab[k] == PH_RELEASED) key_phase_tab[k] = PH_IDLE;
                if (key_phase_tab[k] == PH_HELD) begin
                    held_time[k] = sat_add(held_time[k], c.dt);
                    if (armed[k]) repeat_time[k] = sat_add(repeat_time[k], c.dt);
                end
            end
        end else if (c.cmd == CMD_POLL) begin
            polls_done++;
            r.fire = 1'b0;
            r.phase = PH_IDLE;
            if (int'(c.key) < KEY_COUNT) begin
                r.phase = key_phase_tab[c.key];
                if (r.phase == PH_PRESSED) begin
                    clear_timers(int'(c.key));
                    r.fire = 1'b1;
                end else if (r.phase == PH_HELD) begin
                    // first repeat once the delay has run out, then every period
                    if (!armed[c.key] && held_time[c.key] >= das_cfg) begin
                        armed[c.key] = 1'b1;
                        repeat_time[c.key] = '0;
                        r.fire = 1'b1;
                    end else if (armed[c.key] && repeat_time[c.key] >= arr_cfg) begin
                        repeat_time[c.key] = '0;
                        r.fire = 1'b1;
                    end
                end else begin
                    clear_timers(int'(c.key));
                end
            end
            polls_due.push_back(r);
        end
    endfunction

    function automatic void queue_cmd(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                                      input logic down, input logic [DELTA_W-1:0] dt);
        t_key_cmd c;
        c.cmd = cmd;
        c.key = key;
        c.down = down;
        c.dt = dt;
        pending_cmds.push_back(c);
    endfunction

    // mostly short gaps, a few long ones, and now and then a stretch with none
    function automatic int next_gap(inout int quiet);
        int r;
        if (quiet != 0) begin
            quiet = quiet - 1;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            quiet = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // random traffic around a few keys that are pressed, held, polled and released
    task automatic random_phase(input int n, input int max_dt, input int up_pct,
                                input int tick_pct);
        logic [KEY_W-1:0] keys [6];
        logic [DELTA_W-1:0] dt;
        int made;
        int r;
        int j;
        keys[0] = '0;
        keys[1] = KEY_LAST;
        for (j = 2; j < 6; j++) keys[j] = KEY_W'($urandom_range(0, KEY_COUNT - 1));
        made = 0;
        while (made < n) begin
            r = $urandom_range(0, 99);
            j = $urandom_range(0, 9);
            if (r < tick_pct) begin
                if (j == 0) dt = '0;
                else if (j == 1) dt = DELTA_W'(max_dt);
                else dt = DELTA_W'($urandom_range(0, max_dt));
                queue_cmd(CMD_TICK, KEY_W'($urandom), 1'($urandom), dt);
                made++;
            end else if (r < tick_pct + 25) begin
                queue_cmd(CMD_EVENT, (j == 0) ? KEY_W'($urandom) : keys[$urandom_range(0, 5)],
                          $urandom_range(0, 99) >= up_pct, DELTA_W'($urandom));
                made++;
            end else if (r < 98) begin
                queue_cmd(CMD_POLL, (j == 0) ? KEY_W'($urandom) : keys[$urandom_range(0, 5)],
                          1'($urandom), DELTA_W'($urandom));
                made++;
            end else begin
                queue_cmd(CMD_NONE, KEY_W'($urandom), 1'($urandom), DELTA_W'($urandom));
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_DAS_DELAY) das_cfg = value;
        else if (idx == CFG_ARR_PERIOD) arr_cfg = value;
    endtask

    // events and ticks leave no result behind, so allow the queue to drain too
    task automatic settle();
        do @(posedge i_clk);
        while (pending_cmds.size() != 0 || s_tvalid || polls_due.size() != 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // input stream driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                track_command(cur_cmd);
            end
            if (!s_tvalid || s_tready) begin
                if (tx_gap != 0) begin
                    tx_gap = tx_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_cmds.size() != 0) begin
                    cur_cmd = pending_cmds.pop_front();
                    s_tuser <= cur_cmd.cmd;
                    s_tdata <= {2'b00, cur_cmd.dt, cur_cmd.down, cur_cmd.key};
                    s_tvalid <= 1'b1;
                    tx_gap = next_gap(tx_quiet);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result side ready, with one long hold-off so the input queue backs up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (rx_hold != 0) begin
            rx_hold = rx_hold - 1;
            m_tready <= 1'b0;
        end else if (!long_hold_done && results_checked >= 40) begin
            long_hold_done = 1'b1;
            rx_hold = LONG_HOLD;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 2) == 0) rx_hold = next_gap(rx_quiet);
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_poll_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (polls_due.size() == 0) begin
                $error("unexpected result transfer: fire %0d key_phase %0d",
                       m_tdata[0], m_tdata[2:1]);
                error_count++;
            end else begin
                want = polls_due.pop_front();
                if (m_tdata[0] !== want.fire) begin
                    $error("fire mismatch: expected %0d, actual %0d", want.fire, m_tdata[0]);
                    error_count++;
                end
                if (m_tdata[2:1] !== want.phase) begin
                    $error("key_phase mismatch: expected %0d, actual %0d",
                           want.phase, m_tdata[2:1]);
                    error_count++;
                end
                results_checked++;
                if (want.fire) fires_seen++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, polls_due.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int k;
        das_cfg = DAS_DELAY_RST;
        arr_cfg = ARR_PERIOD_RST;
        for (k = 0; k < KEY_COUNT; k++) begin
            key_phase_tab[k] = PH_IDLE;
            clear_timers(k);
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed walk through the phases with the reset timing
        queue_cmd(CMD_POLL, '0, 1'b0, '0);
        queue_cmd(CMD_EVENT, '0, 1'b1, '0);
        queue_cmd(CMD_POLL, '0, 1'b0, '0);
        queue_cmd(CMD_POLL, '0, 1'b1, DT_FULL);
        queue_cmd(CMD_EVENT, KEY_LAST, 1'b1, DT_FULL);
        queue_cmd(CMD_TICK, KEY_LAST, 1'b1, DT_FULL);
        queue_cmd(CMD_POLL, '0, 1'b0, '0);
        queue_cmd(CMD_POLL, '0, 1'b0, '0);
        queue_cmd(CMD_EVENT, '0, 1'b1, '0);
        queue_cmd(CMD_TICK, '0, 1'b0, '0);
        queue_cmd(CMD_POLL, '0, 1'b0, '0);
        queue_cmd(CMD_TICK, '0, 1'b0, 20'd33000);
        queue_cmd(CMD_POLL, '0, 1'b0, '0);
        queue_cmd(CMD_POLL, KEY_LAST, 1'b1, '0);
        queue_cmd(CMD_EVENT, '0, 1'b0, '0);
        queue_cmd(CMD_POLL, '0, 1'b0, '0);
        queue_cmd(CMD_EVENT, '0, 1'b1, '0);
        queue_cmd(CMD_TICK, '0, 1'b0, 20'd1);
        queue_cmd(CMD_EVENT, KEY_LAST, 1'b0, '0);
        queue_cmd(CMD_TICK, KEY_LAST, 1'b0, 20'hAAAAA);
        queue_cmd(CMD_NONE, KEY_LAST, 1'b1, DT_FULL);
        queue_cmd(CMD_POLL, KEY_LAST, 1'b0, '0);
        queue_cmd(CMD_POLL, '0, 1'b0, '0);
        queue_cmd(CMD_EVENT, 9'h155, 1'b0, 20'h55555);
        queue_cmd(CMD_POLL, 9'h155, 1'b1, '0);

        random_phase(300, 100000, 25, 20);
        settle();
        write_reg(CFG_DAS_DELAY, '0);
        write_reg(CFG_ARR_PERIOD, '0);
        random_phase(300, DT_MAX, 25, 20);
        settle();
        // largest settings only fire once the timers have saturated
        write_reg(CFG_DAS_DELAY, '1);
        write_reg(CFG_ARR_PERIOD, '1);
        random_phase(300, DT_MAX, 3, 35);
        settle();
        write_reg(CFG_DAS_DELAY, CFG_W'($urandom_range(1000, 60000)));
        write_reg(CFG_ARR_PERIOD, CFG_W'($urandom_range(0, 20000)));
        random_phase(300, 20000, 15, 25);
        settle();
        write_reg(CFG_ARR_PERIOD, CFG_W'($urandom));
        write_reg(CFG_DAS_DELAY, CFG_W'($urandom));
        random_phase(300, DT_MAX, 10, 25);
        settle();

        $display("ran %0d key events, %0d ticks and %0d polls over five timing settings",
                 events_done, ticks_done, polls_done);
        $display("checked %0d poll results, %0d of them with a fire pulse",
                 results_checked, fires_seen);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire
